// ===== design/i2cmts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
// Holds the item kinds, bus command and status codes, phases and result word.
// No dependencies; every other design file imports this package.
package i2cmts_pkg;

  // Kind of an input word
  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_PUSH  = 2'd3
  } kind_t;

  // Bus command issued to the two-wire interface
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_SEND    = 3'd3,
    CMD_RD_ACK  = 3'd4,
    CMD_RD_NACK = 3'd5
  } cmd_t;

  // Transaction phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_ADDR  = 2'd2,
    PH_RX    = 2'd3
  } phase_t;

  // Masked status codes reported with a bus event
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK   = 8'h50;
  localparam logic [7:0] ST_RX_NACK  = 8'h58;

  // Result queue depth
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One result word
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] send_byte;
    logic       store_valid;
    logic [3:0] store_index;
    logic [7:0] store_byte;
    logic       busy;
    logic       refused;
    logic       last;
  } result_t;

endpackage

// ===== design/i2cmts_queue.sv =====
// Result queue of the I2C master transaction sequencer.
// Takes one or two result words per cycle and hands them out one at a time.
// Depends on i2cmts_pkg for the result word and queue depth.
module i2cmts_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  i2cmts_pkg::result_t  push_res0,
  input  i2cmts_pkg::result_t  push_res1,
  output logic                 no_room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cmts_pkg::result_t  out_res
);
  import i2cmts_pkg::*;

  result_t          q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             pop;

  // Refuse new words unless two entries are free
  assign no_room   = count_r > Q_CW'(Q_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = q_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    count_nxt  = count_r + Q_CW'(push_cnt) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the words in arrival order
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_mem[wr_ptr_r] <= push_res0;
    end
    if (push_cnt == 2'd2) begin
      q_mem[wr_ptr_r + Q_AW'(1)] <= push_res1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("result queue count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> !no_room)
    else $error("result pushed without two free entries");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd3)
    else $error("more than two results pushed in one cycle");

endmodule

// ===== design/i2c_master_transaction_sequencer_unit.sv =====
// Top level of the I2C master transaction sequencer.
// Decodes each word against the transaction state and queues its results.
// Depends on i2cmts_pkg and i2cmts_queue.
//
//   channel | direction | handshake        | word
//   in_     | input     | valid / stall    | kind, status, bytes, addresses, count
//   out_    | output    | valid / stall    | bus command, stored byte, flags
//   cfg_    | input     | valid / ready    | end-marker byte
//
// An input word is decoded in the cycle it is accepted; its one or two results
// enter a four-entry queue and appear on out_ behind any earlier results.
// One word per cycle is taken while at least two queue entries are free.
// in_stall rises only while fewer than two queue entries are free.
// Reset (rst_n low, synchronous) empties the queue and the transmit buffer
// count and returns to idle; the end marker resets to 0. cfg_ready is always high.
module i2c_master_transaction_sequencer_unit #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_received_byte,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_register_address,
  input  logic [4:0] in_read_count,
  input  logic [7:0] in_push_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_bus_command,
  output logic [7:0] out_send_byte,
  output logic       out_store_valid,
  output logic [3:0] out_store_index,
  output logic [7:0] out_store_byte,
  output logic       out_busy_flag,
  output logic       out_refused,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_end_marker
);
  import i2cmts_pkg::*;

  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int RC_W  = (RX_CW > 5) ? RX_CW : 5;

  // State
  phase_t           phase_r, phase_nxt;
  logic [TX_CW-1:0] fill_r, fill_nxt;
  logic [TX_CW-1:0] ptr_r, ptr_nxt;
  logic [RX_CW-1:0] br_r, br_nxt;
  logic [7:0]       wab_r, wab_nxt;
  logic [7:0]       target_r, target_nxt;
  logic [7:0]       end_marker_r;
  logic [7:0]       head_r;
  logic [7:0]       tx_mem [TX_DEPTH];

  // Decode signals
  kind_t            kind;
  logic             acc;
  logic             busy;
  logic             tx_full;
  logic             head_ok;
  logic             do_stop;
  logic [RX_CW-1:0] br_dec;
  logic [RC_W-1:0]  cnt_sat;
  logic             tx_we;
  logic [TX_AW-1:0] tx_waddr;

  // Queue side
  logic [1:0]       push_cnt;
  result_t          res0, res1, head_res;
  logic             q_no_room;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_no_room;
  assign acc       = in_valid && !in_stall;
  assign kind      = kind_t'(in_kind);
  assign busy      = phase_r != PH_IDLE;
  assign tx_full   = fill_r >= TX_CW'(TX_DEPTH);
  assign head_ok   = (phase_r == PH_WRITE) && (ptr_r < fill_r) && (head_r != end_marker_r);
  assign br_dec    = (br_r != '0) ? br_r - RX_CW'(1) : br_r;
  assign tx_waddr  = fill_r[TX_AW-1:0];

  // Clamp the read count to one .. RX_DEPTH
  always_comb begin
    cnt_sat = RC_W'(in_read_count);
    if (cnt_sat == '0) begin
      cnt_sat = RC_W'(1);
    end
    if (cnt_sat > RC_W'(RX_DEPTH)) begin
      cnt_sat = RC_W'(RX_DEPTH);
    end
  end

  // Decide whether a bus event ends in a stop
  always_comb begin
    do_stop = 1'b0;
    if (kind == KIND_EVENT && busy) begin
      unique case (in_bus_status)
        ST_START, ST_SLAW_ACK, ST_SLAR_ACK, ST_RX_ACK: do_stop = 1'b0;
        ST_DATA_ACK: do_stop = !head_ok;
        default:     do_stop = 1'b1;
      endcase
    end
  end

  // Next transaction state
  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    br_nxt     = br_r;
    wab_nxt    = wab_r;
    target_nxt = target_r;
    tx_we      = 1'b0;
    if (acc) begin
      unique case (kind)
        KIND_PUSH: begin
          if (!busy && !tx_full) begin
            tx_we    = 1'b1;
            fill_nxt = fill_r + TX_CW'(1);
          end
        end
        KIND_WRITE, KIND_READ: begin
          if (!busy) begin
            wab_nxt    = {in_device_address, 1'b0};
            target_nxt = in_register_address;
            if (kind == KIND_WRITE) begin
              phase_nxt = PH_WRITE;
              ptr_nxt   = '0;
            end else begin
              phase_nxt = PH_ADDR;
              br_nxt    = RX_CW'(cnt_sat);
            end
          end
        end
        KIND_EVENT: begin
          if (busy) begin
            if (in_bus_status == ST_DATA_ACK && head_ok) begin
              ptr_nxt = ptr_r + TX_CW'(1);
            end
            if (in_bus_status == ST_RX_ACK) begin
              br_nxt = br_dec;
            end
            if (do_stop) begin
              priority if (phase_r == PH_ADDR) begin
                phase_nxt = PH_RX;
              end else if (phase_r == PH_WRITE) begin
                phase_nxt = PH_IDLE;
                fill_nxt  = '0;
                ptr_nxt   = '0;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result words for the accepted input word
  always_comb begin
    res0       = '0;
    res1       = '0;
    res0.cmd   = CMD_NONE;
    res1.cmd   = CMD_START;
    res0.last  = 1'b1;
    res1.last  = 1'b1;
    res0.busy  = phase_nxt != PH_IDLE;
    res1.busy  = phase_nxt != PH_IDLE;
    push_cnt   = acc ? 2'd1 : 2'd0;
    unique case (kind)
      KIND_PUSH: begin
        res0.refused = busy || tx_full;
      end
      KIND_WRITE, KIND_READ: begin
        if (busy) begin
          res0.refused = 1'b1;
        end else begin
          res0.cmd = CMD_START;
        end
      end
      KIND_EVENT: begin
        if (busy) begin
          unique case (in_bus_status)
            ST_START: begin
              res0.cmd       = CMD_SEND;
              res0.send_byte = (phase_r == PH_RX) ? {wab_r[7:1], 1'b1} : wab_r;
            end
            ST_SLAW_ACK: begin
              res0.cmd       = CMD_SEND;
              res0.send_byte = target_r;
            end
            ST_DATA_ACK: begin
              if (head_ok) begin
                res0.cmd       = CMD_SEND;
                res0.send_byte = head_r;
              end
            end
            ST_SLAR_ACK: begin
              res0.cmd = (br_r > RX_CW'(1)) ? CMD_RD_ACK : CMD_RD_NACK;
            end
            ST_RX_ACK: begin
              res0.store_valid = 1'b1;
              res0.store_index = 4'(br_dec);
              res0.store_byte  = in_received_byte;
              res0.cmd = (br_dec > RX_CW'(1)) ? CMD_RD_ACK : CMD_RD_NACK;
            end
            ST_RX_NACK: begin
              res0.store_valid = 1'b1;
              res0.store_byte  = in_received_byte;
            end
            default: ;
          endcase
          if (do_stop) begin
            res0.cmd = CMD_STOP;
            if (phase_r == PH_ADDR) begin
              res0.last = 1'b0;
              push_cnt  = acc ? 2'd2 : 2'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      fill_r       <= '0;
      ptr_r        <= '0;
      br_r         <= '0;
      wab_r        <= '0;
      target_r     <= '0;
      end_marker_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      ptr_r    <= ptr_nxt;
      br_r     <= br_nxt;
      wab_r    <= wab_nxt;
      target_r <= target_nxt;
      if (cfg_valid && cfg_ready) begin
        end_marker_r <= cfg_end_marker;
      end
    end
  end

  // Transmit buffer write
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= in_push_byte;
    end
  end

  // Prefetch the byte at the next read pointer, passing a same-cycle write through
  always_ff @(posedge clk) begin
    if (tx_we && tx_waddr == ptr_nxt[TX_AW-1:0]) begin
      head_r <= in_push_byte;
    end else begin
      head_r <= tx_mem[ptr_nxt[TX_AW-1:0]];
    end
  end

  i2cmts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_res0 (res0),
    .push_res1 (res1),
    .no_room   (q_no_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head_res)
  );

  // Drive the result ports
  assign out_bus_command = head_res.cmd;
  assign out_send_byte   = head_res.send_byte;
  assign out_store_valid = head_res.store_valid;
  assign out_store_index = head_res.store_index;
  assign out_store_byte  = head_res.store_byte;
  assign out_busy_flag   = head_res.busy;
  assign out_refused     = head_res.refused;
  assign out_last_of_run = head_res.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TX_CW'(TX_DEPTH))
    else $error("transmit fill above buffer depth");

  a_ptr_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= fill_r)
    else $error("transmit pointer ahead of fill");

  a_addr_to_rx: assert property (@(posedge clk) disable iff (!rst_n)
    acc && do_stop && phase_r == PH_ADDR |=> phase_r == PH_RX)
    else $error("stop in read address phase did not enter receive");

  a_busy_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    acc && busy && kind == KIND_PUSH |=> fill_r == $past(fill_r))
    else $error("push taken while busy");

endmodule
